// ===== src/lcdns_pkg.sv =====
// Shared types, codes and constants for the character LCD nibble sequencer.
`default_nettype none

package lcdns_pkg;

    // Request codes carried in the action field
    localparam logic [2:0] ACT_INIT  = 3'd0;
    localparam logic [2:0] ACT_CLEAR = 3'd1;
    localparam logic [2:0] ACT_CHAR  = 3'd2;
    localparam logic [2:0] ACT_INT   = 3'd3;
    localparam logic [2:0] ACT_GOTO  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_FUNCTION_SET = 3'd0;
    localparam logic [2:0] CFG_CONFIG       = 3'd1;
    localparam logic [2:0] CFG_DISPLAY_ON   = 3'd2;
    localparam logic [2:0] CFG_ENTRY_MODE   = 3'd3;
    localparam logic [2:0] CFG_CLEAR        = 3'd4;

    // Register reset values
    localparam logic [7:0] RST_FUNCTION_SET = 8'd2;
    localparam logic [7:0] RST_CONFIG       = 8'd40;
    localparam logic [7:0] RST_DISPLAY_ON   = 8'd12;
    localparam logic [7:0] RST_ENTRY_MODE   = 8'd6;
    localparam logic [7:0] RST_CLEAR        = 8'd1;

    // DDRAM line base addresses with the set-address bit
    localparam logic [7:0] LINE1_BASE = 8'h80;
    localparam logic [7:0] LINE2_BASE = 8'hC0;
    localparam logic [7:0] LINE3_BASE = 8'h94;
    localparam logic [7:0] LINE4_BASE = 8'hD4;

    // Upper nibble of the ASCII digits
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    // Waits after each write, in microseconds
    localparam logic [12:0] WAIT_HIGH  = 13'd0;
    localparam logic [12:0] WAIT_BYTE  = 13'd40;
    localparam logic [12:0] WAIT_CLEAR = 13'd5040;

    // Divide by ten: q = (v * RECIP10) >> RECIP10_SHIFT, exact for 32-bit v
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    // Default sizes
    localparam int DIGITS_DEFAULT = 7;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Last init byte index (clear)
    localparam logic [2:0] INIT_LAST_IDX = 3'd4;

    // One byte to send: register select, the byte, clear wait, end of request
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       clr;
        logic       last;
    } lcd_byte_t;

endpackage

`default_nettype wire

// ===== src/lcdns_front.sv =====
// Front end: takes requests, holds the command registers and turns requests into bytes.
`default_nettype none

module lcdns_front #(
    parameter int DIGITS = lcdns_pkg::DIGITS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // request stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [55:0]        s_tdata,
    // configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,
    // byte queue write side
    output logic                    push,
    output lcdns_pkg::lcd_byte_t    push_byte,
    input  wire logic               queue_full
);
    import lcdns_pkg::*;

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(DIGITS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SEQ  = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIND = 6'b010000,
        S_INT  = 6'b100000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [7:0] fset_reg, cfgc_reg, don_reg, emode_reg, clr_reg;

    logic [2:0]       action_reg;
    logic [7:0]       char_reg;
    logic [2:0]       row_reg;
    logic [4:0]       col_reg;
    logic [2:0]       seq_idx_reg, seq_idx_next;
    logic [31:0]      val_reg, val_next;
    logic [63:0]      prod_reg;
    logic [IDX_W-1:0] dig_idx_reg, dig_idx_next;
    logic [3:0]       digits_reg [DIGITS];

    logic [2:0]  in_action;
    logic [7:0]  in_char;
    logic [31:0] in_value;
    logic [2:0]  in_row;
    logic [4:0]  in_col;
    logic        accept;
    logic        push_last;
    logic [28:0] quot;
    logic [31:0] rem_full;
    logic [IDX_W-1:0] first_idx;
    logic [7:0]  line_base;
    lcd_byte_t   seq_byte;

    // Unpack the request word
    assign in_action = s_tdata[2:0];
    assign in_char   = s_tdata[10:3];
    assign in_value  = s_tdata[42:11];
    assign in_row    = s_tdata[45:43];
    assign in_col    = s_tdata[50:46];

    assign cfg_ready = 1'b1;

    // Command registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fset_reg  <= RST_FUNCTION_SET;
            cfgc_reg  <= RST_CONFIG;
            don_reg   <= RST_DISPLAY_ON;
            emode_reg <= RST_ENTRY_MODE;
            clr_reg   <= RST_CLEAR;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FUNCTION_SET: fset_reg  <= cfg_data;
                CFG_CONFIG:       cfgc_reg  <= cfg_data;
                CFG_DISPLAY_ON:   don_reg   <= cfg_data;
                CFG_ENTRY_MODE:   emode_reg <= cfg_data;
                CFG_CLEAR:        clr_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Line base for goto; out-of-range rows select line four
    always_comb begin
        unique case (row_reg)
            3'd1:    line_base = LINE1_BASE;
            3'd2:    line_base = LINE2_BASE;
            3'd3:    line_base = LINE3_BASE;
            default: line_base = LINE4_BASE;
        endcase
    end

    // Byte for the fixed-length requests
    always_comb begin
        seq_byte = '{rs: 1'b0, data: clr_reg, clr: 1'b1, last: 1'b1};
        unique case (action_reg)
            ACT_INIT: begin
                seq_byte.last = (seq_idx_reg == INIT_LAST_IDX);
                seq_byte.clr  = (seq_idx_reg == INIT_LAST_IDX);
                unique case (seq_idx_reg)
                    CFG_FUNCTION_SET: seq_byte.data = fset_reg;
                    CFG_CONFIG:       seq_byte.data = cfgc_reg;
                    CFG_DISPLAY_ON:   seq_byte.data = don_reg;
                    CFG_ENTRY_MODE:   seq_byte.data = emode_reg;
                    default:          seq_byte.data = clr_reg;
                endcase
            end
            ACT_CHAR: begin
                seq_byte.rs   = 1'b1;
                seq_byte.data = char_reg;
                seq_byte.clr  = 1'b0;
            end
            ACT_GOTO: begin
                // column counts from one; address wraps in eight bits
                seq_byte.data = line_base + {3'b000, col_reg} + 8'hFF;
                seq_byte.clr  = 1'b0;
            end
            default: ;
        endcase
    end

    // Divide by ten and remainder
    assign quot     = prod_reg[63:RECIP10_SHIFT];
    assign rem_full = val_reg - ({quot, 3'b000} + {2'b00, quot, 1'b0});

    // Most significant nonzero digit, or the ones digit when all are zero
    always_comb begin
        first_idx = IDX_TOP;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            if (digits_reg[i] != 4'd0) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    // Queue write
    always_comb begin
        push      = 1'b0;
        push_last = 1'b0;
        push_byte = seq_byte;
        if (state_reg == S_SEQ) begin
            push      = !queue_full;
            push_last = seq_byte.last;
        end else if (state_reg == S_INT) begin
            push      = !queue_full;
            push_last = (dig_idx_reg == IDX_TOP);
            push_byte = '{rs: 1'b1, data: {ASCII_DIGIT_HI, digits_reg[dig_idx_reg]},
                          clr: 1'b0, last: push_last};
        end
    end

    // Take the next request in the cycle the current one finishes
    assign s_tready = (state_reg == S_IDLE) || (push && push_last);
    assign accept   = s_tvalid && s_tready;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        seq_idx_next = seq_idx_reg;
        val_next     = val_reg;
        dig_idx_next = dig_idx_reg;
        unique case (state_reg)
            S_IDLE: ;
            S_SEQ: begin
                if (push) begin
                    seq_idx_next = seq_idx_reg + 3'd1;
                    if (push_last) state_next = S_IDLE;
                end
            end
            S_MUL: state_next = S_DIV;
            S_DIV: begin
                val_next = {3'b000, quot};
                if (dig_idx_reg == '0) begin
                    state_next = S_FIND;
                end else begin
                    dig_idx_next = dig_idx_reg - 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_FIND: begin
                dig_idx_next = first_idx;
                state_next   = S_INT;
            end
            S_INT: begin
                if (push) begin
                    if (push_last) state_next = S_IDLE;
                    else dig_idx_next = dig_idx_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Load a new request
        if (accept) begin
            seq_idx_next = 3'd0;
            val_next     = in_value;
            dig_idx_next = IDX_TOP;
            case (in_action) inside
                ACT_INIT, ACT_CLEAR, ACT_CHAR, ACT_GOTO: state_next = S_SEQ;
                ACT_INT: state_next = S_MUL;
                default: state_next = S_IDLE;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Request payload and conversion data
    always_ff @(posedge aclk) begin
        seq_idx_reg <= seq_idx_next;
        val_reg     <= val_next;
        dig_idx_reg <= dig_idx_next;
        prod_reg    <= 64'(val_reg) * 64'(RECIP10);
        if (accept) begin
            action_reg <= in_action;
            char_reg   <= in_char;
            row_reg    <= in_row;
            col_reg    <= in_col;
        end
        if (state_reg == S_DIV) begin
            digits_reg[dig_idx_reg] <= rem_full[3:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/lcdns_fifo.sv =====
// Short byte queue between the front end and the nibble writer.
`default_nettype none

module lcdns_fifo #(
    parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire lcdns_pkg::lcd_byte_t push_byte,
    output logic                    full,
    input  wire logic               pop,
    output lcdns_pkg::lcd_byte_t    pop_byte,
    output logic                    empty
);
    import lcdns_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);

    lcd_byte_t        store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_byte = store_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_TOP) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_TOP) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_byte;
        end
    end

endmodule

`default_nettype wire

// ===== src/lcdns_back.sv =====
// Back end: splits queued bytes into high and low nibble words with their waits.
`default_nettype none

module lcdns_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // byte queue read side
    output logic                    pop,
    input  wire lcdns_pkg::lcd_byte_t pop_byte,
    input  wire logic               queue_empty,
    // nibble stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata,
    output logic [0:0]              m_tuser,
    output logic                    m_tlast
);
    import lcdns_pkg::*;

    lcd_byte_t   hold_reg;
    logic        hold_valid_reg;
    logic        out_valid_reg;
    logic        out_rs_reg;
    logic [3:0]  out_nibble_reg;
    logic [12:0] out_wait_reg;
    logic        out_last_reg;
    logic        load;

    // Output slot is free or being emptied this cycle
    assign load = !out_valid_reg || m_tready;
    assign pop  = load && !hold_valid_reg && !queue_empty;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (load) begin
            if (hold_valid_reg) begin
                hold_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end else if (!queue_empty) begin
                hold_valid_reg <= 1'b1;
                out_valid_reg  <= 1'b1;
            end else begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // Payload: high nibble first, then low nibble with the byte's wait
    always_ff @(posedge aclk) begin
        if (load) begin
            if (hold_valid_reg) begin
                out_rs_reg     <= hold_reg.rs;
                out_nibble_reg <= hold_reg.data[3:0];
                out_wait_reg   <= hold_reg.clr ? WAIT_CLEAR : WAIT_BYTE;
                out_last_reg   <= hold_reg.last;
            end else if (!queue_empty) begin
                hold_reg       <= pop_byte;
                out_rs_reg     <= pop_byte.rs;
                out_nibble_reg <= pop_byte.data[7:4];
                out_wait_reg   <= WAIT_HIGH;
                out_last_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'd0, out_wait_reg, out_nibble_reg};
    assign m_tuser[0] = out_rs_reg;
    assign m_tlast    = out_last_reg;

endmodule

`default_nettype wire

// ===== src/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer: front end, byte queue, nibble writer.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata: action, char_code, int_value, row, col
//  m_        out  m_tvalid/m_tready    m_tdata: nibble, wait_us; m_tuser: register_select;
//                                      m_tlast: last
//  cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  While m_tready is high and bytes are queued, words leave at one per cycle, two per byte:
//  B bytes give 2*B words per request (init 10, clear/char/goto 2, integer 2 to 2*DIGITS).
//  Integer conversion runs in the front end, one digit per S_MUL/S_DIV pass (multiply by the
//  reciprocal of ten, then remainder); S_FIND then picks the first digit to queue.
//  The byte queue lets the front end accept and convert while the output stalls.
//  Reset (aresetn low, synchronous) empties the queue and restores the command registers.
`default_nettype none

module char_lcd_nibble_sequencer #(
    parameter int DIGITS      = lcdns_pkg::DIGITS_DEFAULT,
    parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] action, [10:3] char_code, [42:11] int_value, [45:43] row, [50:46] col
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] nibble, [16:4] wait_us
    output logic [23:0]      m_tdata,
    // [0] register_select
    output logic [0:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import lcdns_pkg::*;

    lcd_byte_t push_byte;
    lcd_byte_t pop_byte;
    logic      push, pop, queue_full, queue_empty;

    lcdns_front #(
        .DIGITS(DIGITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_byte  (push_byte),
        .queue_full (queue_full)
    );

    lcdns_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_byte (push_byte),
        .full      (queue_full),
        .pop       (pop),
        .pop_byte  (pop_byte),
        .empty     (queue_empty)
    );

    lcdns_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop         (pop),
        .pop_byte    (pop_byte),
        .queue_empty (queue_empty),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
